// File: rtl/core/cbs_pkg.sv
// cubic bezier split: shared types and constants
// no dependencies; used by every module of the block
`default_nettype none

package cbs_pkg;

  // pipeline depth from the input transfer to the output register
  localparam int NUM_STAGES = 6;

  // per-stage load enables, driven by the pipeline control
  typedef struct packed {
    logic mul1;  // first-level products
    logic add1;  // first-level points a, m, c
    logic mul2;  // second-level products
    logic add2;  // second-level points l, r
    logic mul3;  // knot product
    logic outr;  // output register
  } stage_en_t;

endpackage : cbs_pkg

`default_nettype wire

// File: rtl/core/cbs_in_if.sv
// cubic bezier split: input channel, four control points and split parameter
// no dependencies
`default_nettype none

interface cbs_in_if #(
  parameter int CW = 20,
  parameter int TB = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] p0_x;
  logic signed [CW-1:0] p0_y;
  logic signed [CW-1:0] p1_x;
  logic signed [CW-1:0] p1_y;
  logic signed [CW-1:0] p2_x;
  logic signed [CW-1:0] p2_y;
  logic signed [CW-1:0] p3_x;
  logic signed [CW-1:0] p3_y;
  logic [TB:0]          split_t;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, split_t,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, split_t,
    output ready
  );
endinterface : cbs_in_if

`default_nettype wire

// File: rtl/core/cbs_out_if.sv
// cubic bezier split: result channel, the five points of the split
// no dependencies
`default_nettype none

interface cbs_out_if #(
  parameter int CW = 20
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] l_x;
  logic signed [CW-1:0] l_y;
  logic signed [CW-1:0] k_x;
  logic signed [CW-1:0] k_y;
  logic signed [CW-1:0] r_x;
  logic signed [CW-1:0] r_y;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;

  modport source (
    output valid, a_x, a_y, l_x, l_y, k_x, k_y, r_x, r_y, c_x, c_y,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, l_x, l_y, k_x, k_y, r_x, r_y, c_x, c_y,
    output ready
  );
endinterface : cbs_out_if

`default_nettype wire

// File: rtl/core/cbs_ctrl.sv
// cubic bezier split: pipeline valid bits and per-stage load enables
// depends on cbs_pkg
`default_nettype none

module cbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cbs_pkg::stage_en_t    en
);

  localparam int NS = cbs_pkg::NUM_STAGES;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_nxt;
  logic [NS-1:0] rdy;

  // a stage loads when it is empty or its content moves on this cycle
  always_comb begin
    rdy[NS-1] = ~valid_r[NS-1] | out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = ~valid_r[k] | rdy[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NS; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    in_ready  = rdy[0];
    out_valid = valid_r[NS-1];
    en.mul1   = rdy[0];
    en.add1   = rdy[1];
    en.mul2   = rdy[2];
    en.add2   = rdy[3];
    en.mul3   = rdy[4];
    en.outr   = rdy[5];
  end

endmodule : cbs_ctrl

`default_nettype wire

// File: rtl/core/cbs_lane.sv
// cubic bezier split: one coordinate lane, three pipelined lerp levels
// depends on cbs_pkg; one instance per axis
`default_nettype none

module cbs_lane #(
  parameter int CW = 20,
  parameter int TB = 16
) (
  input  wire logic                 clk,
  input  wire cbs_pkg::stage_en_t   en,
  input  wire logic signed [CW-1:0] p0,
  input  wire logic signed [CW-1:0] p1,
  input  wire logic signed [CW-1:0] p2,
  input  wire logic signed [CW-1:0] p3,
  input  wire logic [TB:0]          t,
  output logic signed [CW-1:0]      a,
  output logic signed [CW-1:0]      l,
  output logic signed [CW-1:0]      k,
  output logic signed [CW-1:0]      r,
  output logic signed [CW-1:0]      c
);

  // |b - a| <= 2^CW and t <= 2^TB, so the product needs CW+TB+2 signed bits
  localparam int PW = CW + TB + 2;
  localparam logic signed [PW-1:0] HALF = {{(PW-TB){1'b0}}, 1'b1, {(TB-1){1'b0}}};

  function automatic logic signed [PW-1:0] lerp_mul(
    input logic signed [CW-1:0] x0,
    input logic signed [CW-1:0] x1,
    input logic [TB:0]          tt
  );
    logic signed [PW-1:0] d;
    logic signed [PW-1:0] te;
    d  = PW'(x1) - PW'(x0);
    te = $signed(PW'(tt));
    return d * te;
  endfunction

  // round half up, floor shift, add the base point
  function automatic logic signed [CW-1:0] lerp_fin(
    input logic signed [CW-1:0] x0,
    input logic signed [PW-1:0] prod
  );
    logic signed [PW-1:0] s;
    s = prod + HALF;
    return x0 + CW'(s >>> TB);
  endfunction

  logic signed [CW-1:0] s1_p0_r, s1_p1_r, s1_p2_r;
  logic signed [PW-1:0] s1_pa_r, s1_pm_r, s1_pc_r;
  logic [TB:0]          s1_t_r;

  logic signed [CW-1:0] s2_a_r, s2_m_r, s2_c_r;
  logic [TB:0]          s2_t_r;

  logic signed [CW-1:0] s3_a_r, s3_m_r, s3_c_r;
  logic signed [PW-1:0] s3_pl_r, s3_pr_r;
  logic [TB:0]          s3_t_r;

  logic signed [CW-1:0] s4_a_r, s4_l_r, s4_r_r, s4_c_r;
  logic [TB:0]          s4_t_r;

  logic signed [CW-1:0] s5_a_r, s5_l_r, s5_r_r, s5_c_r;
  logic signed [PW-1:0] s5_pk_r;

  always_ff @(posedge clk) begin
    if (en.mul1) begin
      s1_p0_r <= p0;
      s1_p1_r <= p1;
      s1_p2_r <= p2;
      s1_pa_r <= lerp_mul(p0, p1, t);
      s1_pm_r <= lerp_mul(p1, p2, t);
      s1_pc_r <= lerp_mul(p2, p3, t);
      s1_t_r  <= t;
    end
    if (en.add1) begin
      s2_a_r <= lerp_fin(s1_p0_r, s1_pa_r);
      s2_m_r <= lerp_fin(s1_p1_r, s1_pm_r);
      s2_c_r <= lerp_fin(s1_p2_r, s1_pc_r);
      s2_t_r <= s1_t_r;
    end
    if (en.mul2) begin
      s3_a_r  <= s2_a_r;
      s3_m_r  <= s2_m_r;
      s3_c_r  <= s2_c_r;
      s3_pl_r <= lerp_mul(s2_a_r, s2_m_r, s2_t_r);
      s3_pr_r <= lerp_mul(s2_m_r, s2_c_r, s2_t_r);
      s3_t_r  <= s2_t_r;
    end
    if (en.add2) begin
      s4_a_r <= s3_a_r;
      s4_l_r <= lerp_fin(s3_a_r, s3_pl_r);
      s4_r_r <= lerp_fin(s3_m_r, s3_pr_r);
      s4_c_r <= s3_c_r;
      s4_t_r <= s3_t_r;
    end
    if (en.mul3) begin
      s5_a_r  <= s4_a_r;
      s5_l_r  <= s4_l_r;
      s5_r_r  <= s4_r_r;
      s5_c_r  <= s4_c_r;
      s5_pk_r <= lerp_mul(s4_l_r, s4_r_r, s4_t_r);
    end
  end

  // knot add is finished in front of the output register
  always_comb begin
    a = s5_a_r;
    l = s5_l_r;
    k = lerp_fin(s5_l_r, s5_pk_r);
    r = s5_r_r;
    c = s5_c_r;
  end

endmodule : cbs_lane

`default_nettype wire

// File: rtl/core/cbs_merge.sv
// cubic bezier split: output register joining the x and y lanes
// depends on cbs_pkg
`default_nettype none

module cbs_merge #(
  parameter int CW = 20
) (
  input  wire logic                 clk,
  input  wire cbs_pkg::stage_en_t   en,
  input  wire logic signed [CW-1:0] x_a,
  input  wire logic signed [CW-1:0] x_l,
  input  wire logic signed [CW-1:0] x_k,
  input  wire logic signed [CW-1:0] x_r,
  input  wire logic signed [CW-1:0] x_c,
  input  wire logic signed [CW-1:0] y_a,
  input  wire logic signed [CW-1:0] y_l,
  input  wire logic signed [CW-1:0] y_k,
  input  wire logic signed [CW-1:0] y_r,
  input  wire logic signed [CW-1:0] y_c,
  output logic signed [CW-1:0]      a_x,
  output logic signed [CW-1:0]      a_y,
  output logic signed [CW-1:0]      l_x,
  output logic signed [CW-1:0]      l_y,
  output logic signed [CW-1:0]      k_x,
  output logic signed [CW-1:0]      k_y,
  output logic signed [CW-1:0]      r_x,
  output logic signed [CW-1:0]      r_y,
  output logic signed [CW-1:0]      c_x,
  output logic signed [CW-1:0]      c_y
);

  logic signed [CW-1:0] a_x_r, a_y_r, l_x_r, l_y_r, k_x_r;
  logic signed [CW-1:0] k_y_r, r_x_r, r_y_r, c_x_r, c_y_r;

  always_ff @(posedge clk) begin
    if (en.outr) begin
      a_x_r <= x_a;
      a_y_r <= y_a;
      l_x_r <= x_l;
      l_y_r <= y_l;
      k_x_r <= x_k;
      k_y_r <= y_k;
      r_x_r <= x_r;
      r_y_r <= y_r;
      c_x_r <= x_c;
      c_y_r <= y_c;
    end
  end

  assign a_x = a_x_r;
  assign a_y = a_y_r;
  assign l_x = l_x_r;
  assign l_y = l_y_r;
  assign k_x = k_x_r;
  assign k_y = k_y_r;
  assign r_x = r_x_r;
  assign r_y = r_y_r;
  assign c_x = c_x_r;
  assign c_y = c_y_r;

endmodule : cbs_merge

`default_nettype wire

// File: rtl/core/cubic_bezier_split_unit.sv
// cubic bezier split: de casteljau subdivision of one cubic segment per item
// depends on cbs_pkg, cbs_in_if, cbs_out_if, cbs_ctrl, cbs_lane, cbs_merge
//
//   channel   dir   payload                                   handshake
//   in_ch     in    p0..p3 x/y (Q15.4), split_t (Q1.16)       valid / ready
//   out_ch    out   a, l, k, r, c x/y (Q15.4)                 valid / ready
//
// one item per cycle unless back-pressure from out_ch fills the pipe; six register
// stages, the last of them the output register that shows the result
// the stages form three lerp levels, each a multiply stage and an add stage,
// the last add feeding the output register
// each stage loads when empty or draining, so bubbles close up under stalls
// reset clears the stage valid bits only
`default_nettype none

module cubic_bezier_split_unit #(
  parameter int COORD_WIDTH = 20,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cbs_in_if.sink     in_ch,
  cbs_out_if.source  out_ch
);

  localparam int CW = COORD_WIDTH;
  localparam int TB = T_FRAC_BITS;

  cbs_pkg::stage_en_t en;

  logic [TB:0]          t_sat;
  logic signed [CW-1:0] x_a, x_l, x_k, x_r, x_c;
  logic signed [CW-1:0] y_a, y_l, y_k, y_r, y_c;

  // t above one is clamped to one
  always_comb begin
    if (in_ch.split_t[TB] && (|in_ch.split_t[TB-1:0])) begin
      t_sat = {1'b1, {TB{1'b0}}};
    end else begin
      t_sat = in_ch.split_t;
    end
  end

  cbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .en        (en)
  );

  cbs_lane #(.CW(CW), .TB(TB)) u_lane_x (
    .clk (clk),
    .en  (en),
    .p0  (in_ch.p0_x),
    .p1  (in_ch.p1_x),
    .p2  (in_ch.p2_x),
    .p3  (in_ch.p3_x),
    .t   (t_sat),
    .a   (x_a),
    .l   (x_l),
    .k   (x_k),
    .r   (x_r),
    .c   (x_c)
  );

  cbs_lane #(.CW(CW), .TB(TB)) u_lane_y (
    .clk (clk),
    .en  (en),
    .p0  (in_ch.p0_y),
    .p1  (in_ch.p1_y),
    .p2  (in_ch.p2_y),
    .p3  (in_ch.p3_y),
    .t   (t_sat),
    .a   (y_a),
    .l   (y_l),
    .k   (y_k),
    .r   (y_r),
    .c   (y_c)
  );

  cbs_merge #(.CW(CW)) u_merge (
    .clk (clk),
    .en  (en),
    .x_a (x_a),
    .x_l (x_l),
    .x_k (x_k),
    .x_r (x_r),
    .x_c (x_c),
    .y_a (y_a),
    .y_l (y_l),
    .y_k (y_k),
    .y_r (y_r),
    .y_c (y_c),
    .a_x (out_ch.a_x),
    .a_y (out_ch.a_y),
    .l_x (out_ch.l_x),
    .l_y (out_ch.l_y),
    .k_x (out_ch.k_x),
    .k_y (out_ch.k_y),
    .r_x (out_ch.r_x),
    .r_y (out_ch.r_y),
    .c_x (out_ch.c_x),
    .c_y (out_ch.c_y)
  );

endmodule : cubic_bezier_split_unit

`default_nettype wire

// File: rtl/core/cbs_checker.sv
// cubic bezier split: port-level checks on transfers and occupancy
// depends on cbs_pkg; bound to cubic_bezier_split_unit
`default_nettype none

module cbs_checker #(
  parameter int DW = 200
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [DW-1:0] out_data
);

  localparam int CNT_W = $clog2(cbs_pkg::NUM_STAGES + 2);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // items inside the block, seen from the ports
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(cbs_pkg::NUM_STAGES))
    else $error("more items inside than pipeline stages");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result shown with no item inside");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule : cbs_checker

bind cubic_bezier_split_unit cbs_checker #(.DW(10 * COORD_WIDTH)) u_cbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.a_x, out_ch.a_y, out_ch.l_x, out_ch.l_y, out_ch.k_x,
               out_ch.k_y, out_ch.r_x, out_ch.r_y, out_ch.c_x, out_ch.c_y})
);

`default_nettype wire

// File: dv/tb_cubic_bezier_split_unit.sv
// testbench for cubic_bezier_split_unit: directed table then random segments under idling
// needs cbs_pkg, cbs_in_if, cbs_out_if and the unit itself; every split is predicted here
// and checked in transfer order
`default_nettype none

module tb_cubic_bezier_split_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 20;
  localparam int TB = 16;
  localparam int CMIN = -(1 << (CW - 1));
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int T_MAX = (1 << (TB + 1)) - 1;
  localparam longint T_ONE = longint'(1) << TB;
  localparam longint T_HALF = longint'(1) << (TB - 1);
  localparam int RAND_PER_PHASE = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;

  // index 0..7: p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
  typedef struct packed {
    logic [7:0][CW-1:0] pt;
    logic [TB:0]        t;
  } seg_t;

  // index 0..9: a_x a_y l_x l_y k_x k_y r_x r_y c_x c_y
  typedef logic [9:0][CW-1:0] pts_t;

  typedef struct packed {
    seg_t seg;
    bit   typed;
    pts_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  cbs_in_if  #(.CW(CW), .TB(TB)) in_ch ();
  cbs_out_if #(.CW(CW))          out_ch ();

  cubic_bezier_split_unit #(
    .COORD_WIDTH(CW),
    .T_FRAC_BITS(TB)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pts_t     split_q[$];
  dir_row_t dir_tab[$];
  string    pt_name [10] = '{"a_x", "a_y", "l_x", "l_y", "k_x", "k_y",
                             "r_x", "r_y", "c_x", "c_y"};

  int n_err;
  int n_sent;
  int n_checked;
  int quiet_cycles;
  int send_idle_pct;
  int stall_pct;
  bit hold_off;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint lerp_q(longint a, longint b, longint t);
    return a + (((b - a) * t + T_HALF) >>> TB);
  endfunction

  function automatic pts_t split_segment(seg_t s);
    longint px[4];
    longint py[4];
    longint tt;
    longint ax, ay, mx, my, cx, cy, lx, ly, rx, ry, kx, ky;
    pts_t   r;
    tt = (s.t > T_ONE) ? T_ONE : longint'(s.t);
    for (int i = 0; i < 4; i++) begin
      px[i] = longint'($signed(s.pt[2*i]));
      py[i] = longint'($signed(s.pt[2*i+1]));
    end
    ax = lerp_q(px[0], px[1], tt);
    ay = lerp_q(py[0], py[1], tt);
    mx = lerp_q(px[1], px[2], tt);
    my = lerp_q(py[1], py[2], tt);
    cx = lerp_q(px[2], px[3], tt);
    cy = lerp_q(py[2], py[3], tt);
    lx = lerp_q(ax, mx, tt);
    ly = lerp_q(ay, my, tt);
    rx = lerp_q(mx, cx, tt);
    ry = lerp_q(my, cy, tt);
    kx = lerp_q(lx, rx, tt);
    ky = lerp_q(ly, ry, tt);
    r[0] = ax[CW-1:0];
    r[1] = ay[CW-1:0];
    r[2] = lx[CW-1:0];
    r[3] = ly[CW-1:0];
    r[4] = kx[CW-1:0];
    r[5] = ky[CW-1:0];
    r[6] = rx[CW-1:0];
    r[7] = ry[CW-1:0];
    r[8] = cx[CW-1:0];
    r[9] = cy[CW-1:0];
    return r;
  endfunction

  function automatic seg_t mk_seg(int p0x, int p0y, int p1x, int p1y,
                                  int p2x, int p2y, int p3x, int p3y, int t);
    seg_t s;
    s.pt = {p3y[CW-1:0], p3x[CW-1:0], p2y[CW-1:0], p2x[CW-1:0],
            p1y[CW-1:0], p1x[CW-1:0], p0y[CW-1:0], p0x[CW-1:0]};
    s.t  = t[TB:0];
    return s;
  endfunction

  function automatic pts_t mk_pts(int axv, int ayv, int lxv, int lyv, int kxv, int kyv,
                                  int rxv, int ryv, int cxv, int cyv);
    return {cyv[CW-1:0], cxv[CW-1:0], ryv[CW-1:0], rxv[CW-1:0], kyv[CW-1:0],
            kxv[CW-1:0], lyv[CW-1:0], lxv[CW-1:0], ayv[CW-1:0], axv[CW-1:0]};
  endfunction

  // offer one segment, idling first at the current rate; the split is queued on transfer
  task automatic offer_seg(input seg_t s, input bit typed, input pts_t want);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.p0_x    <= s.pt[0];
    in_ch.p0_y    <= s.pt[1];
    in_ch.p1_x    <= s.pt[2];
    in_ch.p1_y    <= s.pt[3];
    in_ch.p2_x    <= s.pt[4];
    in_ch.p2_y    <= s.pt[5];
    in_ch.p3_x    <= s.pt[6];
    in_ch.p3_y    <= s.pt[7];
    in_ch.split_t <= s.t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    split_q.push_back(typed ? want : split_segment(s));
    n_sent++;
  endtask

  // receiver: random stalls, plus the long hold-off while the pipe fills
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    pts_t got;
    pts_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.c_y, out_ch.c_x, out_ch.r_y, out_ch.r_x, out_ch.k_y,
             out_ch.k_x, out_ch.l_y, out_ch.l_x, out_ch.a_y, out_ch.a_x};
      if (split_q.size() == 0) begin
        if (n_err < MAX_REPORTS)
          $display("%0t: split with none expected, knot got (%0d,%0d)",
                   $time, $signed(got[4]), $signed(got[5]));
        n_err++;
      end else begin
        want = split_q.pop_front();
        n_checked++;
        for (int i = 0; i < 10; i++) begin
          if (got[i] !== want[i]) begin
            if (n_err < MAX_REPORTS)
              $display("%0t: split %0d %s expected %0d got %0d", $time, n_checked,
                       pt_name[i], $signed(want[i]), $signed(got[i]));
            n_err++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d splits outstanding",
               $time, QUIET_LIMIT, split_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    seg_t s;
    int   n_dir;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.p0_x    = '0;
    in_ch.p0_y    = '0;
    in_ch.p1_x    = '0;
    in_ch.p1_y    = '0;
    in_ch.p2_x    = '0;
    in_ch.p2_y    = '0;
    in_ch.p3_x    = '0;
    in_ch.p3_y    = '0;
    in_ch.split_t = '0;
    n_err         = 0;
    n_sent        = 0;
    n_checked     = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off      = 1'b0;

    // t = 0 puts a, l and k on p0, t = 1 puts k, r and c on p3; t above one behaves as one
    dir_tab.push_back('{mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_tab.push_back('{mk_seg(100, -200, 300, 400, -500, 600, 700, -800, 0), 1'b1,
                        mk_pts(100, -200, 100, -200, 100, -200, 300, 400, -500, 600)});
    dir_tab.push_back('{mk_seg(100, -200, 300, 400, -500, 600, 700, -800, 65536), 1'b1,
                        mk_pts(300, 400, -500, 600, 700, -800, 700, -800, 700, -800)});
    dir_tab.push_back('{mk_seg(100, -200, 300, 400, -500, 600, 700, -800, T_MAX), 1'b1,
                        mk_pts(300, 400, -500, 600, 700, -800, 700, -800, 700, -800)});
    dir_tab.push_back('{mk_seg(100, -200, 300, 400, -500, 600, 700, -800, 65537), 1'b1,
                        mk_pts(300, 400, -500, 600, 700, -800, 700, -800, 700, -800)});
    dir_tab.push_back('{mk_seg(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 0), 1'b1,
                        mk_pts(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX)});
    dir_tab.push_back('{mk_seg(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 65536), 1'b1,
                        mk_pts(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN)});
    dir_tab.push_back('{mk_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 32768), 1'b1,
                        mk_pts(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX)});
    dir_tab.push_back('{mk_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 12345), 1'b1,
                        mk_pts(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN)});
    // full-swing deltas and rounding around the half step
    dir_tab.push_back('{mk_seg(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 32768), 1'b0, '0});
    dir_tab.push_back('{mk_seg(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1), 1'b0, '0});
    dir_tab.push_back('{mk_seg(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 65535), 1'b0, '0});
    dir_tab.push_back('{mk_seg(0, 0, 1, -1, 0, 0, 1, -1, 32768), 1'b0, '0});
    dir_tab.push_back('{mk_seg(0, 0, -1, 1, 3, -3, -5, 5, 32767), 1'b0, '0});
    dir_tab.push_back('{mk_seg(0, 0, -1, 1, 3, -3, -5, 5, 32769), 1'b0, '0});
    // alternating bit patterns in coordinates and t
    dir_tab.push_back('{mk_seg(349525, -349526, -349526, 349525, 349525, -349526,
                               -349526, 349525, 43690), 1'b0, '0});
    dir_tab.push_back('{mk_seg(-349526, 349525, 349525, -349526, -349526, 349525,
                               349525, -349526, 21845), 1'b0, '0});
    dir_tab.push_back('{mk_seg(-349526, 349525, 349525, -349526, -349526, 349525,
                               349525, -349526, 87381), 1'b0, '0});
    dir_tab.push_back('{mk_seg(1000, 2000, -3000, 4000, 5000, -6000, -7000, -8000, 16384),
                        1'b0, '0});

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) offer_seg(dir_tab[i].seg, dir_tab[i].typed, dir_tab[i].want);
    n_dir = dir_tab.size();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      // long receiver hold-off while the sender keeps offering at full rate
      if (ph == 0)
        fork
          begin
            @(posedge clk);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      repeat (RAND_PER_PHASE) begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(0, 9))
            0:       s.pt[i] = CMIN[CW-1:0];
            1:       s.pt[i] = CMAX[CW-1:0];
            2, 3, 4: s.pt[i] = CW'($urandom_range(0, 200) - 100);
            default: s.pt[i] = CW'($urandom());
          endcase
        end
        case ($urandom_range(0, 9))
          0:       s.t = '0;
          1:       s.t = T_ONE[TB:0];
          2:       s.t = (TB+1)'($urandom_range(65537, T_MAX));
          default: s.t = (TB+1)'($urandom_range(0, 65536));
        endcase
        offer_seg(s, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (split_q.size() != 0) @(posedge clk);
    repeat (2 * cbs_pkg::NUM_STAGES) @(posedge clk);

    $display("covered %0d segments (%0d from the table: t at zero, one and above one, extreme",
             n_sent, n_dir);
    $display("  points, rounding), %0d splits checked; idling none/sender/receiver/both, one hold-off",
             n_checked);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_cubic_bezier_split_unit

`default_nettype wire
